// File: src/bft_pkg.sv
`default_nettype none

package bft_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [31:0] MatcherStep = 32'd2;

  typedef struct packed {
    logic [31:0] hash;
    logic        is_ipv6;
    logic [7:0]  protocol;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] matcher;
  } entry_t;

  typedef struct packed {
    logic fwd;
    logic rev;
  } match_t;

  // ipv4 compares only the low 32 bits of the low word
  function automatic logic addr_eq(logic v6, logic [63:0] ah, logic [63:0] al,
                                   logic [63:0] bh, logic [63:0] bl);
    logic res;
    if (v6) begin
      res = (ah == bh) && (al == bl);
    end else begin
      res = (al[31:0] == bl[31:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/bft_cell.sv
`default_nettype none

module bft_cell (
  input  wire               clk_i,
  input  wire               shift_i,
  input  wire               load_i,
  input  bft_pkg::entry_t   neighbor_i,
  input  bft_pkg::entry_t   load_data_i,
  output bft_pkg::entry_t   entry_o
);

  bft_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = load_data_i;
    end else if (shift_i) begin
      entry_d = neighbor_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: src/bft_match.sv
`default_nettype none

module bft_match (
  input  bft_pkg::key_t   key_i,
  input  bft_pkg::entry_t entry_i,
  output bft_pkg::match_t match_o
);

  logic v6;
  logic icmp;
  logic head_eq;
  logic ports_fwd;
  logic ports_swp;
  logic addr_fwd;
  logic addr_rev;

  assign v6 = key_i.is_ipv6;
  assign icmp = (key_i.protocol == bft_pkg::ProtoIcmp);
  assign head_eq = (entry_i.key.hash == key_i.hash) &&
                   (entry_i.key.is_ipv6 == key_i.is_ipv6) &&
                   (entry_i.key.protocol == key_i.protocol);
  assign ports_fwd = (entry_i.key.src_port == key_i.src_port) &&
                     (entry_i.key.dst_port == key_i.dst_port);
  assign ports_swp = (entry_i.key.src_port == key_i.dst_port) &&
                     (entry_i.key.dst_port == key_i.src_port);
  assign addr_fwd = bft_pkg::addr_eq(v6, entry_i.key.src_high, entry_i.key.src_low,
                                     key_i.src_high, key_i.src_low) &&
                    bft_pkg::addr_eq(v6, entry_i.key.dst_high, entry_i.key.dst_low,
                                     key_i.dst_high, key_i.dst_low);
  assign addr_rev = bft_pkg::addr_eq(v6, entry_i.key.src_high, entry_i.key.src_low,
                                     key_i.dst_high, key_i.dst_low) &&
                    bft_pkg::addr_eq(v6, entry_i.key.dst_high, entry_i.key.dst_low,
                                     key_i.src_high, key_i.src_low);

  // icmp type and code are never swapped
  assign match_o.fwd = head_eq && addr_fwd && ports_fwd;
  assign match_o.rev = head_eq && addr_rev && (icmp ? ports_fwd : ports_swp);

endmodule

`default_nettype wire

// File: src/bidirectional_flow_table.sv
`default_nettype none

// bidirectional five-tuple flow table. each input item is a parsed flow key;
// the block looks it up among the stored flows with the same hash, in order of
// insertion, matching either the same direction or the swapped one (icmp type
// and code are compared unswapped). a hit returns the stored matcher index and
// the direction; a miss stores the key with the next matcher index (0, 2, 4,
// ...) or reports table_full when all slots are taken. flows are never
// removed. the table is a ring of cells that rotates one slot per cycle past a
// single compare unit while the scan runs, so every item is scanned over all
// Entries slots and then finishes and inserts in a final state, at whose end
// the result item is registered as valid. one item is in flight at a time; the
// next is accepted the cycle after the result has been taken.
module bidirectional_flow_table (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // hash_value[31:0], protocol[39:32], src_addr_high[103:40],
  // src_addr_low[167:104], dst_addr_high[231:168], dst_addr_low[295:232],
  // src_port[311:296], dst_port[327:312]
  input  wire [327:0]  s_axis_tdata_i,
  // is_ipv6
  input  wire          s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  // found[0], reverse_direction[1], matcher_index[33:2], table_full[34], zero pad
  output logic [39:0]  m_axis_tdata_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e state_q, state_d;

  bft_pkg::key_t              key_q;
  logic [bft_pkg::IdxW-1:0]   cnt_q, cnt_d;
  logic [bft_pkg::CntW-1:0]   fill_q, fill_d;
  logic [31:0]                next_matcher_q, next_matcher_d;
  logic                       hit_q, hit_d;
  logic                       hit_rev_q, hit_rev_d;
  logic [31:0]                hit_matcher_q, hit_matcher_d;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q, rev_q, full_q;
  logic [31:0]                matcher_q;

  logic                       in_acc;
  logic                       out_acc;
  logic                       shift;
  logic                       do_insert;
  logic                       slot_valid;
  bft_pkg::match_t            match;
  bft_pkg::entry_t            ins_entry;
  bft_pkg::entry_t            ring [bft_pkg::Entries];

  assign s_axis_tready_o = (state_q == StIdle) && !out_valid_q;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // ring rotates toward cell 0 every scan cycle and is home again at the end
  assign shift = (state_q == StScan);
  assign do_insert = (state_q == StFin) && !hit_q &&
                     (fill_q != bft_pkg::CntW'(bft_pkg::Entries));
  assign ins_entry.key = key_q;
  assign ins_entry.matcher = next_matcher_q;

  for (genvar k = 0; k < bft_pkg::Entries; k++) begin : g_cell
    bft_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .load_i      (do_insert && (fill_q == bft_pkg::CntW'(k))),
      .neighbor_i  (ring[(k + 1) % bft_pkg::Entries]),
      .load_data_i (ins_entry),
      .entry_o     (ring[k])
    );
  end

  bft_match u_match (
    .key_i   (key_q),
    .entry_i (ring[0]),
    .match_o (match)
  );

  // cell 0 holds slot cnt_q during the scan; only filled slots count
  assign slot_valid = (bft_pkg::CntW'(cnt_q) < fill_q);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    fill_d = fill_q;
    next_matcher_d = next_matcher_q;
    hit_d = hit_q;
    hit_rev_d = hit_rev_q;
    hit_matcher_d = hit_matcher_q;
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StScan;
          cnt_d = '0;
          hit_d = 1'b0;
        end
      end
      StScan: begin
        if (slot_valid && !hit_q && (match.fwd || match.rev)) begin
          hit_d = 1'b1;
          hit_rev_d = !match.fwd;
          hit_matcher_d = ring[0].matcher;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == bft_pkg::IdxW'(bft_pkg::Entries - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
        if (do_insert) begin
          fill_d = fill_q + 1'b1;
          next_matcher_d = next_matcher_q + bft_pkg::MatcherStep;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      fill_q <= '0;
      next_matcher_q <= '0;
      hit_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      fill_q <= fill_d;
      next_matcher_q <= next_matcher_d;
      hit_q <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_rev_q <= hit_rev_d;
    hit_matcher_q <= hit_matcher_d;
    if (in_acc) begin
      key_q.hash     <= s_axis_tdata_i[31:0];
      key_q.is_ipv6  <= s_axis_tuser_i;
      key_q.protocol <= s_axis_tdata_i[39:32];
      key_q.src_high <= s_axis_tdata_i[103:40];
      key_q.src_low  <= s_axis_tdata_i[167:104];
      key_q.dst_high <= s_axis_tdata_i[231:168];
      key_q.dst_low  <= s_axis_tdata_i[295:232];
      key_q.src_port <= s_axis_tdata_i[311:296];
      key_q.dst_port <= s_axis_tdata_i[327:312];
    end
    // result register, loaded as the scan finishes
    if (state_q == StFin) begin
      found_q <= hit_q;
      rev_q <= hit_q && hit_rev_q;
      full_q <= !hit_q && !do_insert;
      if (hit_q) begin
        matcher_q <= hit_matcher_q;
      end else if (do_insert) begin
        matcher_q <= next_matcher_q;
      end else begin
        matcher_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = {5'b0, full_q, matcher_q, rev_q, found_q};

  a_out_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == StIdle))
    else $error("result shown while a lookup runs");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= bft_pkg::CntW'(bft_pkg::Entries))
    else $error("fill count past table size");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StScan) && (cnt_q == '0))
    else $error("accepted item did not start a scan");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) && !hit_q && !do_insert |->
      (fill_q == bft_pkg::CntW'(bft_pkg::Entries)))
    else $error("table full reported with free slots");

endmodule

`default_nettype wire
